@@ hw/rtl/kmp_pkg.sv @@
// kmp_pkg: operation and status codes, result record and helpers for the kmp matcher
// depends on nothing; used by kmp_core, kmp_stream_matcher and kmp_checker

package kmp_pkg;

  // field widths fixed by the interface
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned PLEN_W  = 7;
  localparam int unsigned TOTAL_W = 32;

  // pattern_length value after reset
  localparam logic [PLEN_W-1:0] PLEN_RESET = 7'd1;

  // operation codes, code 3 is unused
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ORDER      = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LCMP,
    S_TCMP,
    S_TWRAP,
    S_FIN
  } state_e;

  // one result transaction as handed from the core to the output register
  typedef struct packed {
    logic                 match_found;
    logic [TOTAL_W-1:0]   match_total;
    logic [TOTAL_W-1:0]   comparison_total;
    status_e              status;
  } res_t;

  // saturating increment of a total
  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] x);
    return (x == '1) ? x : x + 32'd1;
  endfunction

endpackage

@@ hw/rtl/kmp_ram.sv @@
// kmp_ram: simple dual-port synchronous memory, one write and one registered read port
// no dependencies; holds the pattern bytes or the prefix-failure table

module kmp_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/kmp_core.sv @@
// kmp_core: sequencer for pattern load, prefix build and text scan over the two memories
// depends on kmp_pkg; drives the ports of the pattern and prefix kmp_ram instances

module kmp_core #(
  parameter int unsigned MAX_PATTERN = 64,
  parameter int unsigned AW          = $clog2(MAX_PATTERN),
  parameter int unsigned PW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input transaction
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [kmp_pkg::OP_W-1:0]   operation_i,
  input  logic [kmp_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [kmp_pkg::IDX_W-1:0]  pattern_index_i,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [PW-1:0]              len_i,
  // result towards the output register
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output kmp_pkg::res_t              res_o,
  // pattern memory
  output logic                       pat_we_o,
  output logic [AW-1:0]              pat_waddr_o,
  output logic [kmp_pkg::BYTE_W-1:0] pat_wdata_o,
  output logic [AW-1:0]              pat_raddr_o,
  input  logic [kmp_pkg::BYTE_W-1:0] pat_rdata_i,
  // prefix memory
  output logic                       pre_we_o,
  output logic [AW-1:0]              pre_waddr_o,
  output logic [PW-1:0]              pre_wdata_o,
  output logic [AW-1:0]              pre_raddr_o,
  input  logic [PW-1:0]              pre_rdata_i
);

  kmp_pkg::state_e state_q, state_d;

  logic [kmp_pkg::BYTE_W-1:0]  byte_q, byte_d;
  logic [kmp_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [PW-1:0]               ptr_q, ptr_d;
  logic [PW-1:0]               loaded_q, loaded_d;
  logic [PW-1:0]               bpl_q, bpl_d;
  logic [PW-1:0]               mpos_q, mpos_d;
  logic [kmp_pkg::TOTAL_W-1:0] mcnt_q, mcnt_d;
  logic [kmp_pkg::TOTAL_W-1:0] ccnt_q, ccnt_d;
  logic                        found_q, found_d;
  kmp_pkg::status_e            status_q, status_d;

  logic          acc;
  logic          op_load, op_text, op_restart;
  logic          idx_zero, order_bad, incomplete;
  logic          pat_eq, full_hit;
  logic [PW-1:0] j0, ptr_inc, rd_ptr;

  // decode of the accepted transaction
  assign in_ready_o = (state_q == kmp_pkg::S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign op_load    = (operation_i == kmp_pkg::OP_LOAD);
  assign op_text    = (operation_i == kmp_pkg::OP_TEXT);
  assign op_restart = (operation_i == kmp_pkg::OP_RESTART);
  assign idx_zero   = (pattern_index_i == '0);
  assign order_bad  = (32'(pattern_index_i) != 32'(loaded_q)) || (loaded_q >= len_i);
  assign incomplete = (loaded_q < len_i);
  assign j0         = (mpos_q >= len_i) ? '0 : mpos_q;

  // byte test against the pattern entry read last cycle
  assign pat_eq   = (pat_rdata_i == byte_q);
  assign ptr_inc  = ptr_q + 1'b1;
  assign full_hit = (state_q == kmp_pkg::S_TCMP) && pat_eq && (ptr_inc == len_i);

  // read addresses: start point on accept, table fallback while comparing
  assign rd_ptr      = (state_q == kmp_pkg::S_IDLE) ? (op_load ? bpl_q : j0) : pre_rdata_i;
  assign pat_raddr_o = AW'(rd_ptr);
  assign pre_raddr_o = full_hit ? AW'(len_i - 1'b1) : AW'(rd_ptr - 1'b1);

  // pattern byte is written on the accept edge of a legal load
  assign pat_we_o    = acc && op_load && (idx_zero || !order_bad);
  assign pat_waddr_o = AW'(pattern_index_i);
  assign pat_wdata_o = data_byte_i;

  assign res_valid_o = (state_q == kmp_pkg::S_FIN);
  assign res_o       = '{match_found: found_q, match_total: mcnt_q,
                         comparison_total: ccnt_q, status: status_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmp_pkg::S_IDLE: begin
        if (acc) begin
          if (op_load && !idx_zero && !order_bad) begin
            state_d = kmp_pkg::S_LCMP;
          end else if (op_text && !incomplete) begin
            state_d = kmp_pkg::S_TCMP;
          end else begin
            state_d = kmp_pkg::S_FIN;
          end
        end
      end
      kmp_pkg::S_LCMP: begin
        if (pat_eq || (ptr_q == '0)) begin
          state_d = kmp_pkg::S_FIN;
        end
      end
      kmp_pkg::S_TCMP: begin
        if (full_hit) begin
          state_d = kmp_pkg::S_TWRAP;
        end else if (pat_eq || (ptr_q == '0)) begin
          state_d = kmp_pkg::S_FIN;
        end
      end
      kmp_pkg::S_TWRAP: begin
        state_d = kmp_pkg::S_FIN;
      end
      kmp_pkg::S_FIN: begin
        if (res_ready_i) begin
          state_d = kmp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kmp_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and prefix memory writes
  always_comb begin
    byte_d      = byte_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    loaded_d    = loaded_q;
    bpl_d       = bpl_q;
    mpos_d      = mpos_q;
    mcnt_d      = mcnt_q;
    ccnt_d      = ccnt_q;
    found_d     = found_q;
    status_d    = status_q;
    pre_we_o    = 1'b0;
    pre_waddr_o = AW'(idx_q);
    pre_wdata_o = '0;
    unique case (state_q)
      kmp_pkg::S_IDLE: begin
        if (acc) begin
          byte_d   = data_byte_i;
          idx_d    = pattern_index_i;
          found_d  = 1'b0;
          status_d = kmp_pkg::ST_OK;
          if (op_load) begin
            if (idx_zero) begin
              // new pattern starts
              pre_we_o    = 1'b1;
              pre_waddr_o = '0;
              pre_wdata_o = '0;
              bpl_d       = '0;
              loaded_d    = PW'(1);
              mpos_d      = '0;
            end else if (order_bad) begin
              status_d = kmp_pkg::ST_ORDER;
            end else begin
              ptr_d = bpl_q;
            end
          end else if (op_text) begin
            if (incomplete) begin
              status_d = kmp_pkg::ST_INCOMPLETE;
            end else begin
              ptr_d = j0;
            end
          end else if (op_restart) begin
            mpos_d = '0;
            mcnt_d = '0;
            ccnt_d = '0;
          end
        end
      end
      kmp_pkg::S_LCMP: begin
        // prefix build: fall back until the byte matches or the length is zero
        if (pat_eq || (ptr_q == '0)) begin
          pre_we_o    = 1'b1;
          pre_wdata_o = pat_eq ? ptr_inc : '0;
          bpl_d       = pat_eq ? ptr_inc : '0;
          loaded_d    = PW'(32'(idx_q) + 32'd1);
        end else begin
          ptr_d = pre_rdata_i;
        end
      end
      kmp_pkg::S_TCMP: begin
        ccnt_d = kmp_pkg::sat_inc(ccnt_q);
        if (full_hit) begin
          found_d = 1'b1;
          mcnt_d  = kmp_pkg::sat_inc(mcnt_q);
        end else if (pat_eq) begin
          mpos_d = ptr_inc;
        end else if (ptr_q == '0) begin
          mpos_d = '0;
        end else begin
          ptr_d = pre_rdata_i;
        end
      end
      kmp_pkg::S_TWRAP: begin
        // after a full match continue from the last table entry
        mpos_d = pre_rdata_i;
      end
      kmp_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase
    // a length write restarts the match position
    if (cfg_we_i) begin
      mpos_d = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kmp_pkg::S_IDLE;
      loaded_q <= '0;
      bpl_q    <= '0;
      mpos_q   <= '0;
      mcnt_q   <= '0;
      ccnt_q   <= '0;
      found_q  <= 1'b0;
      status_q <= kmp_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      bpl_q    <= bpl_d;
      mpos_q   <= mpos_d;
      mcnt_q   <= mcnt_d;
      ccnt_q   <= ccnt_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    idx_q  <= idx_d;
    ptr_q  <= ptr_d;
  end

endmodule

@@ hw/rtl/kmp_stream_matcher.sv @@
// kmp_stream_matcher: top level, length register, memories, sequencer and output register
// depends on kmp_pkg, kmp_ram and kmp_core
//
//   channel   direction  handshake                signals
//   in        input      in_valid_i / in_ready_o  operation_i data_byte_i pattern_index_i
//   out       output     out_valid_o / out_ready_i match_found_o match_total_o
//                                                 comparison_total_o status_o
//   cfg       input      cfg_we_i (no wait)       cfg_wdata_i (pattern_length)
//
// one transaction at a time; restart, index 0 load, bad load, early text: accept, then result
// in-order load: accept, prefix-build byte tests (one table hop per cycle), result
// text byte: accept, byte tests, S_TWRAP when it completes an occurrence, result;
// the single read port of each memory sets one test per cycle
// reset clears control state only; memory entries are written before they are read
// a stalled output register holds the next result in the sequencer, input waits meanwhile

module kmp_stream_matcher #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kmp_pkg::OP_W-1:0]    operation_i,
  input  logic [kmp_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [kmp_pkg::IDX_W-1:0]   pattern_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        match_found_o,
  output logic [kmp_pkg::TOTAL_W-1:0] match_total_o,
  output logic [kmp_pkg::TOTAL_W-1:0] comparison_total_o,
  output logic [1:0]                  status_o,
  input  logic                        cfg_we_i,
  input  logic [kmp_pkg::PLEN_W-1:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_PATTERN);
  localparam int unsigned PW = $clog2(MAX_PATTERN + 1);

  logic [kmp_pkg::PLEN_W-1:0] plen_q;
  logic [PW-1:0]              len;

  logic                       res_valid, res_ready;
  kmp_pkg::res_t              res;
  logic                       out_valid_q, out_valid_d;
  kmp_pkg::res_t              out_q;

  logic                       pat_we;
  logic [AW-1:0]              pat_waddr, pat_raddr;
  logic [kmp_pkg::BYTE_W-1:0] pat_wdata, pat_rdata;
  logic                       pre_we;
  logic [AW-1:0]              pre_waddr, pre_raddr;
  logic [PW-1:0]              pre_wdata, pre_rdata;

  // pattern length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= kmp_pkg::PLEN_RESET;
    end else if (cfg_we_i) begin
      plen_q <= cfg_wdata_i;
    end
  end

  // effective length: zero acts as one, clamp to the memory depth
  always_comb begin
    if (plen_q == '0) begin
      len = PW'(1);
    end else if (32'(plen_q) > MAX_PATTERN) begin
      len = PW'(MAX_PATTERN);
    end else begin
      len = PW'(plen_q);
    end
  end

  kmp_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (kmp_pkg::BYTE_W)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  kmp_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (PW)
  ) u_pre_ram (
    .clk_i   (clk_i),
    .we_i    (pre_we),
    .waddr_i (pre_waddr),
    .wdata_i (pre_wdata),
    .raddr_i (pre_raddr),
    .rdata_o (pre_rdata)
  );

  kmp_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .AW          (AW),
    .PW          (PW)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .data_byte_i     (data_byte_i),
    .pattern_index_i (pattern_index_i),
    .cfg_we_i        (cfg_we_i),
    .len_i           (len),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .pat_we_o        (pat_we),
    .pat_waddr_o     (pat_waddr),
    .pat_wdata_o     (pat_wdata),
    .pat_raddr_o     (pat_raddr),
    .pat_rdata_i     (pat_rdata),
    .pre_we_o        (pre_we),
    .pre_waddr_o     (pre_waddr),
    .pre_wdata_o     (pre_wdata),
    .pre_raddr_o     (pre_raddr),
    .pre_rdata_i     (pre_rdata)
  );

  // output register, loads when empty or when being drained
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign match_found_o      = out_q.match_found;
  assign match_total_o      = out_q.match_total;
  assign comparison_total_o = out_q.comparison_total;
  assign status_o           = out_q.status;

endmodule

@@ hw/rtl/kmp_checker.sv @@
// kmp_checker: port-level assertions for kmp_stream_matcher, bound to the top level
// depends on kmp_pkg

module kmp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        match_found_o,
  input logic [kmp_pkg::TOTAL_W-1:0] match_total_o,
  input logic [kmp_pkg::TOTAL_W-1:0] comparison_total_o,
  input logic [1:0]                  status_o
);

  // a stalled output transaction keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_total_o)
      && $stable(comparison_total_o) && $stable(status_o) && $stable(match_found_o))
    else $error("output transaction changed while stalled");

  // a match is only reported for a text byte that was handled normally
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_found_o |-> status_o == kmp_pkg::ST_OK)
    else $error("match reported with error status");

  // every match costs at least one byte test
  a_total_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> comparison_total_o >= match_total_o)
    else $error("match total exceeds comparison total");

  // a reported match is counted
  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_found_o |-> match_total_o != '0)
    else $error("match reported with zero total");

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (.*);
